### rtl/core/sync_frame_deframer_crc16_unit_macros.svh
// assertion macros used by the deframer frame logic
`ifndef SYNC_FRAME_DEFRAMER_CRC16_UNIT_MACROS_SVH
`define SYNC_FRAME_DEFRAMER_CRC16_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sfd_pkg.sv
// package: constants, types and crc step for the sync frame deframer
package sfd_pkg;

  localparam int FRAME_LEN_DEF    = 64;
  localparam int BUFFER_DEPTH_DEF = 256;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  SYNC_RESET = 8'hAA;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] byte_offset;
    logic       last;
    logic       crc_ok;
    logic       aborted;
  } result_t;

  // crc-16/modbus update over one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/sfd_ifs.sv
// valid/ready channel interfaces for received bytes and frame results
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [7:0] byte_offset;
  logic       last;
  logic       crc_ok;
  logic       aborted;

  modport source (output valid, output frame_byte, output byte_offset, output last,
                  output crc_ok, output aborted, input ready);
  modport sink (input valid, input frame_byte, input byte_offset, input last,
                input crc_ok, input aborted, output ready);
endinterface

### rtl/core/sfd_in_stage.sv
// input register for received bytes
module sfd_in_stage (
  input  logic            clk,
  input  logic            rst,
  sfd_in_if.sink          rx,
  input  logic            advance,
  output sfd_pkg::stage_t held
);

  sfd_pkg::stage_t stage;

  assign rx.ready = !stage.valid || advance;
  assign held     = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
    if (rx.valid && rx.ready) begin
      stage.data <= rx.rx_byte;
    end
  end

endmodule

### rtl/core/sfd_frame_logic.sv
// frame hunt, offset tracking, crc check and overflow abort
`include "sync_frame_deframer_crc16_unit_macros.svh"

module sfd_frame_logic #(
  parameter int FRAME_LEN    = sfd_pkg::FRAME_LEN_DEF,
  parameter int BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_in,
  input  logic [7:0]       sync_value,
  output logic             res_valid,
  output sfd_pkg::result_t res
);

  localparam int HC_W = $clog2(BUFFER_DEPTH);
  localparam logic [HC_W-1:0] HELD_MAX   = HC_W'(BUFFER_DEPTH - 1);
  localparam logic [7:0]      LAST_POS   = 8'(FRAME_LEN - 1);
  localparam logic [7:0]      CRC_LO_POS = 8'(FRAME_LEN - 2);

  logic [HC_W-1:0] held_count, held_count_next;
  logic            in_frame, in_frame_next;
  logic [7:0]      frame_pos, frame_pos_next;
  logic [15:0]     crc_acc, crc_acc_next;
  logic            low_match, low_match_next;

  always_comb begin
    held_count_next = held_count;
    in_frame_next   = in_frame;
    frame_pos_next  = frame_pos;
    crc_acc_next    = crc_acc;
    low_match_next  = low_match;
    res_valid       = 1'b0;
    res             = '0;
    if (held_count >= HELD_MAX) begin
      held_count_next = '0;
      in_frame_next   = 1'b0;
      frame_pos_next  = '0;
      crc_acc_next    = sfd_pkg::CRC_INIT;
      low_match_next  = 1'b0;
      res_valid       = 1'b1;
      res.aborted     = 1'b1;
    end else begin
      held_count_next = held_count + 1'b1;
      if (!in_frame) begin
        if (byte_in == sync_value) begin
          in_frame_next  = 1'b1;
          frame_pos_next = 8'd1;
          crc_acc_next   = sfd_pkg::CRC_INIT;
          low_match_next = 1'b0;
          res_valid      = 1'b1;
          res.frame_byte = byte_in;
        end
      end else if (frame_pos >= LAST_POS) begin
        held_count_next = '0;
        in_frame_next   = 1'b0;
        frame_pos_next  = '0;
        crc_acc_next    = sfd_pkg::CRC_INIT;
        low_match_next  = 1'b0;
        res_valid       = 1'b1;
        res.frame_byte  = byte_in;
        res.byte_offset = frame_pos;
        res.last        = 1'b1;
        res.crc_ok      = low_match && (byte_in == crc_acc[15:8]);
      end else begin
        if (frame_pos == CRC_LO_POS) begin
          low_match_next = (byte_in == crc_acc[7:0]);
        end else begin
          crc_acc_next = sfd_pkg::crc_byte(crc_acc, byte_in);
        end
        frame_pos_next  = frame_pos + 8'd1;
        res_valid       = 1'b1;
        res.frame_byte  = byte_in;
        res.byte_offset = frame_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      in_frame   <= 1'b0;
      frame_pos  <= '0;
      crc_acc    <= sfd_pkg::CRC_INIT;
      low_match  <= 1'b0;
    end else if (step) begin
      held_count <= held_count_next;
      in_frame   <= in_frame_next;
      frame_pos  <= frame_pos_next;
      crc_acc    <= crc_acc_next;
      low_match  <= low_match_next;
    end
  end

  `SFD_ASSERT_NOW(a_held_bound, 1'b1, held_count <= HELD_MAX,
                  "held count beyond buffer depth")
  `SFD_ASSERT_NOW(a_pos_hunting, !in_frame, frame_pos == 8'd0,
                  "frame position nonzero while hunting")
  `SFD_ASSERT_NOW(a_last_offset, res_valid && res.last,
                  !res.aborted && res.byte_offset == LAST_POS,
                  "last item not at final frame offset")
  `SFD_ASSERT_NEXT(a_last_rehunt, step && res_valid && (res.last || res.aborted),
                   !in_frame && held_count == '0,
                   "block not hunting after frame end or abort")

endmodule

### rtl/core/sfd_out_stage.sv
// result register toward the receiver
module sfd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfd_pkg::result_t res,
  sfd_out_if.source        tx,
  output logic             free
);

  logic             valid;
  sfd_pkg::result_t data;

  assign free           = !valid || tx.ready;
  assign tx.valid       = valid;
  assign tx.frame_byte  = data.frame_byte;
  assign tx.byte_offset = data.byte_offset;
  assign tx.last        = data.last;
  assign tx.crc_ok      = data.crc_ok;
  assign tx.aborted     = data.aborted;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (tx.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

### rtl/core/sync_frame_deframer_crc16_unit.sv
// top level: sync-byte fixed-length deframer with crc-16/modbus check
//
// rx carries received bytes, one item per byte, valid/ready handshake.
// tx carries one item per frame byte: the byte, its offset (sync byte is
// offset 0), last on the final byte with crc_ok, or an aborted item with
// all other fields zero when the held-byte count reaches BUFFER_DEPTH - 1.
// Bytes seen while hunting for the sync value give no tx item.
// cfg_we/cfg_wdata write the sync value; write it only while idle.
// Path: an accepted byte is held in the input register, processed by the
// frame logic and registered in the result register that drives tx.
// Throughput: one byte per cycle unless tx stalls; the crc update over a
// byte is a single pass of xor logic from the input register into crc_acc.
// When tx stalls, the result register holds its item and the input
// register holds one more byte; rx ready drops once both are full.
// Reset clears the frame state, empties both registers and sets the sync
// value to 0xAA.
module sync_frame_deframer_crc16_unit #(
  parameter int FRAME_LEN    = sfd_pkg::FRAME_LEN_DEF,
  parameter int BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sfd_in_if.sink     rx,
  sfd_out_if.source  tx,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic             [7:0] sync_value;
  sfd_pkg::stage_t  held;
  sfd_pkg::result_t res;
  logic             res_valid;
  logic             out_free;
  logic             advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= sfd_pkg::SYNC_RESET;
    end else if (cfg_we) begin
      sync_value <= cfg_wdata;
    end
  end

  assign advance = held.valid && out_free;

  sfd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .advance (advance),
    .held    (held)
  );

  sfd_frame_logic #(
    .FRAME_LEN    (FRAME_LEN),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_logic (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .byte_in    (held.data),
    .sync_value (sync_value),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfd_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .load (advance && res_valid),
    .res  (res),
    .tx   (tx),
    .free (out_free)
  );

endmodule
